### rtl/slcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

	localparam int ADDR_W   = 19;
	localparam int SAMPLE_W = 8;
	localparam int CODE_W   = 15;
	localparam int PIXELS   = 1 << ADDR_W;
	localparam int BIT_W    = 4;
	localparam int CAP_W    = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CAP_W-1:0] CAP_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_SELECT   = 3'd0,
		REG_INVERSE_PAIRS = 3'd1,
		REG_USE_GRAY      = 3'd2,
		REG_LOWEST_BIT    = 3'd3,
		REG_PROJ_WIDTH    = 3'd4,
		REG_PROJ_HEIGHT   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_ROWS = 2'd0,
		AXIS_COLS = 2'd1,
		AXIS_BOTH = 2'd2
	} axis_t;

	// What the current capture does to a pixel
	typedef enum logic [1:0] {
		PH_WHITE,
		PH_BLACK,
		PH_POSITIVE,
		PH_COMPARE
	} phase_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   pixel_addr;
		logic [SAMPLE_W-1:0] sample;
		logic                frame_end;
	} pixel_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] out_addr;
		logic [CODE_W-1:0] row_code;
		logic [CODE_W-1:0] col_code;
	} code_word_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] level;
		logic [CODE_W-1:0]   row_code;
		logic [CODE_W-1:0]   col_code;
	} pix_entry_t;

	typedef struct packed {
		phase_t           phase;
		logic             pair_mode;
		logic             use_gray;
		logic [BIT_W-1:0] lowest_bit;
		logic [BIT_W-1:0] bit_pos;
		logic             scanning_columns;
		logic             final_capture;
	} seq_ctrl_t;

	// Floor log2 of a projector size; zero counts as one
	function automatic logic [BIT_W-1:0] top_bit(input logic [CODE_W-1:0] size);
		logic [BIT_W-1:0] t;
		t = '0;
		for (int i = 1; i < CODE_W; i++) begin
			if (size[i]) begin
				t = BIT_W'(i);
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/structured_light_code_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Structured-light code decoder.
// pixel channel (pixel_valid/pixel_ready/pixel): one camera pixel word per
// cycle unless stalled, capture after capture: white, black, then the bit planes from the
// top code bit down (rows, then columns, as axis_select picks); frame_end
// marks the last pixel of each capture.
// code channel (code_valid/code_ready/code): during the final capture every
// pixel yields one word with its camera address and decoded row and column.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
// always ready; write only while the block is idle.
// Throughput: one pixel per cycle unless stalled. A pixel waits in stage one;
// in the final capture its code word then goes to the output register. Each
// pixel does one read-modify-write of a 512K-entry pixel store: read on the
// accept edge, written back when the word leaves stage one, with a same-address bypass.
// Reset: registers take their defaults and the sequence expects white. The
// store is not cleared; the white and black captures write every pixel
// before any plane reads it.
// Stall: a held code word keeps the stage behind it; pixel_ready drops
// only when that stage holds a word that still has to emit a result.
module structured_light_code_decoder (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              pixel_valid,
	output logic                             pixel_ready,
	input  slcd_pkg::pixel_word_t            pixel,
	output logic                             code_valid,
	input  wire                              code_ready,
	output slcd_pkg::code_word_t             code,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [slcd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SUM_W = slcd_pkg::SAMPLE_W + 1;

	logic                        accept;
	logic                        valid_s1;
	slcd_pkg::pixel_word_t       word_s1;
	logic                        fire_s1;
	logic                        out_free;
	logic                        code_valid_q;
	slcd_pkg::code_word_t        code_q;

	slcd_pkg::seq_ctrl_t         ctrl;
	slcd_pkg::pix_entry_t        entry_rd;
	slcd_pkg::pix_entry_t        entry_wr;

	logic [SUM_W-1:0]            level_sum;
	logic                        lit;
	logic [slcd_pkg::CODE_W-1:0] plane_mask;
	logic [slcd_pkg::CODE_W-1:0] row_final;
	logic [slcd_pkg::CODE_W-1:0] col_final;

	// Handshake: the stage moves on unless it owes a result the output cannot take
	assign out_free    = !code_valid_q || code_ready;
	assign fire_s1     = valid_s1 && (!ctrl.final_capture || out_free);
	assign pixel_ready = !valid_s1 || fire_s1;
	assign accept      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= pixel;
		end
	end

	slcd_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (fire_s1),
		.frame_end (word_s1.frame_end),
		.ctrl      (ctrl)
	);

	// Read on accept, write back when the word leaves stage one
	slcd_pixel_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pixel.pixel_addr),
		.wr_en   (fire_s1),
		.wr_addr (word_s1.pixel_addr),
		.wr_data (entry_wr),
		.rd_data (entry_rd)
	);

	assign level_sum  = {1'b0, entry_rd.level} + {1'b0, word_s1.sample};
	// Inverse mode compares the stored positive against the negative capture
	assign lit        = ctrl.pair_mode ? (entry_rd.level >= word_s1.sample)
		: (word_s1.sample >= entry_rd.level);
	assign plane_mask = lit ? (slcd_pkg::CODE_W'(1) << ctrl.bit_pos) : '0;

	always_comb begin
		entry_wr = entry_rd;
		unique case (ctrl.phase)
			slcd_pkg::PH_WHITE: begin
				entry_wr.level = word_s1.sample;
			end
			slcd_pkg::PH_BLACK: begin
				// Store the mean unless in pair mode, clear both codes for the new sequence
				if (!ctrl.pair_mode) begin
					entry_wr.level = level_sum[SUM_W-1:1];
				end
				entry_wr.row_code = '0;
				entry_wr.col_code = '0;
			end
			slcd_pkg::PH_POSITIVE: begin
				entry_wr.level = word_s1.sample;
			end
			slcd_pkg::PH_COMPARE: begin
				if (ctrl.scanning_columns) begin
					entry_wr.col_code = entry_rd.col_code | plane_mask;
				end else begin
					entry_wr.row_code = entry_rd.row_code | plane_mask;
				end
			end
		endcase
	end

	slcd_code_finish u_row_finish (
		.code_in    (entry_wr.row_code),
		.use_gray   (ctrl.use_gray),
		.lowest_bit (ctrl.lowest_bit),
		.code_out   (row_final)
	);

	slcd_code_finish u_col_finish (
		.code_in    (entry_wr.col_code),
		.use_gray   (ctrl.use_gray),
		.lowest_bit (ctrl.lowest_bit),
		.code_out   (col_final)
	);

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (fire_s1 && ctrl.final_capture) begin
			code_valid_q <= 1'b1;
		end else if (code_ready) begin
			code_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && ctrl.final_capture) begin
			code_q.out_addr <= word_s1.pixel_addr;
			code_q.row_code <= row_final;
			code_q.col_code <= col_final;
		end
	end

	assign code_valid = code_valid_q;
	assign code       = code_q;

endmodule

`default_nettype wire

### rtl/slcd_pixel_store.sv
`timescale 1ns / 1ps
`default_nettype none

module slcd_pixel_store (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          rd_en,
	input  wire [slcd_pkg::ADDR_W-1:0]   rd_addr,
	input  wire                          wr_en,
	input  wire [slcd_pkg::ADDR_W-1:0]   wr_addr,
	input  slcd_pkg::pix_entry_t         wr_data,
	output slcd_pkg::pix_entry_t         rd_data
);

	slcd_pkg::pix_entry_t mem [slcd_pkg::PIXELS];
	slcd_pkg::pix_entry_t rdata_q;
	slcd_pkg::pix_entry_t fwd_data_q;
	logic                 fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// Catch a write to the same pixel landing on the read edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

### rtl/slcd_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module slcd_sequencer (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [slcd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              advance,
	input  wire                              frame_end,
	output slcd_pkg::seq_ctrl_t              ctrl
);

	logic [1:0]                   axis_select_q;
	logic                         pair_mode_q;
	logic                         use_gray_q;
	logic [slcd_pkg::BIT_W-1:0]   lowest_bit_q;
	logic [slcd_pkg::CODE_W-1:0]  proj_width_q;
	logic [slcd_pkg::CODE_W-1:0]  proj_height_q;

	logic [slcd_pkg::CAP_W-1:0]   capture_index_q, capture_index_d;
	logic [slcd_pkg::BIT_W-1:0]   bit_pos_q, bit_pos_d;
	logic                         scanning_columns_q, scanning_columns_d;
	logic                         awaiting_negative_q, awaiting_negative_d;

	logic [slcd_pkg::BIT_W-1:0]   top_w, top_h;
	logic                         rows_planned, cols_planned;
	logic                         final_capture;
	logic [slcd_pkg::CAP_W-1:0]   capture_inc;
	slcd_pkg::phase_t             phase;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_select_q <= slcd_pkg::AXIS_BOTH;
			pair_mode_q   <= 1'b0;
			use_gray_q    <= 1'b1;
			lowest_bit_q  <= '0;
			proj_width_q  <= slcd_pkg::CODE_W'(1024);
			proj_height_q <= slcd_pkg::CODE_W'(768);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slcd_pkg::REG_AXIS_SELECT:   axis_select_q <= cfg_data[1:0];
				slcd_pkg::REG_INVERSE_PAIRS: pair_mode_q   <= cfg_data[0];
				slcd_pkg::REG_USE_GRAY:      use_gray_q    <= cfg_data[0];
				slcd_pkg::REG_LOWEST_BIT:    lowest_bit_q  <= cfg_data[slcd_pkg::BIT_W-1:0];
				slcd_pkg::REG_PROJ_WIDTH:    proj_width_q  <= cfg_data;
				slcd_pkg::REG_PROJ_HEIGHT:   proj_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign top_w = slcd_pkg::top_bit(proj_width_q);
	assign top_h = slcd_pkg::top_bit(proj_height_q);
	// Selector three behaves as rows then columns
	assign rows_planned = (axis_select_q != slcd_pkg::AXIS_COLS) && (top_h >= lowest_bit_q);
	assign cols_planned = (axis_select_q != slcd_pkg::AXIS_ROWS) && (top_w >= lowest_bit_q);

	assign capture_inc = (capture_index_q == slcd_pkg::CAP_MAX) ? capture_index_q
		: capture_index_q + 1'b1;

	always_comb begin
		priority if (capture_index_q == '0) begin
			phase = slcd_pkg::PH_WHITE;
		end else if (capture_index_q == slcd_pkg::CAP_W'(1)) begin
			phase = slcd_pkg::PH_BLACK;
		end else if (pair_mode_q && !awaiting_negative_q) begin
			phase = slcd_pkg::PH_POSITIVE;
		end else begin
			phase = slcd_pkg::PH_COMPARE;
		end
	end

	always_comb begin
		unique case (phase)
			slcd_pkg::PH_BLACK:   final_capture = !rows_planned && !cols_planned;
			slcd_pkg::PH_COMPARE: final_capture = (bit_pos_q <= lowest_bit_q)
				&& (scanning_columns_q || !cols_planned);
			default:              final_capture = 1'b0;
		endcase
	end

	always_comb begin
		capture_index_d     = capture_index_q;
		bit_pos_d           = bit_pos_q;
		scanning_columns_d  = scanning_columns_q;
		awaiting_negative_d = awaiting_negative_q;
		if (advance && frame_end) begin
			if (final_capture) begin
				// Sequence done: expect white again
				capture_index_d     = '0;
				bit_pos_d           = '0;
				scanning_columns_d  = 1'b0;
				awaiting_negative_d = 1'b0;
			end else begin
				unique case (phase)
					slcd_pkg::PH_WHITE: begin
						capture_index_d = slcd_pkg::CAP_W'(1);
					end
					slcd_pkg::PH_BLACK: begin
						capture_index_d     = slcd_pkg::CAP_W'(2);
						awaiting_negative_d = 1'b0;
						scanning_columns_d  = !rows_planned;
						bit_pos_d           = rows_planned ? top_h : top_w;
					end
					slcd_pkg::PH_POSITIVE: begin
						awaiting_negative_d = 1'b1;
						capture_index_d     = capture_inc;
					end
					slcd_pkg::PH_COMPARE: begin
						awaiting_negative_d = 1'b0;
						capture_index_d     = capture_inc;
						if (bit_pos_q > lowest_bit_q) begin
							bit_pos_d = bit_pos_q - 1'b1;
						end else begin
							scanning_columns_d = 1'b1;
							bit_pos_d          = top_w;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_index_q     <= '0;
			bit_pos_q           <= '0;
			scanning_columns_q  <= 1'b0;
			awaiting_negative_q <= 1'b0;
		end else begin
			capture_index_q     <= capture_index_d;
			bit_pos_q           <= bit_pos_d;
			scanning_columns_q  <= scanning_columns_d;
			awaiting_negative_q <= awaiting_negative_d;
		end
	end

	assign ctrl.phase            = phase;
	assign ctrl.pair_mode        = pair_mode_q;
	assign ctrl.use_gray         = use_gray_q;
	assign ctrl.lowest_bit       = lowest_bit_q;
	assign ctrl.bit_pos          = bit_pos_q;
	assign ctrl.scanning_columns = scanning_columns_q;
	assign ctrl.final_capture    = final_capture;

endmodule

`default_nettype wire

### rtl/slcd_code_finish.sv
`timescale 1ns / 1ps
`default_nettype none

module slcd_code_finish (
	input  wire [slcd_pkg::CODE_W-1:0] code_in,
	input  wire                        use_gray,
	input  wire [slcd_pkg::BIT_W-1:0]  lowest_bit,
	output logic [slcd_pkg::CODE_W-1:0] code_out
);

	logic [slcd_pkg::CODE_W-1:0] bin;
	logic [slcd_pkg::CODE_W-1:0] low_mask;

	// Gray to binary: each bit is the parity of itself and all bits above
	always_comb begin
		for (int i = 0; i < slcd_pkg::CODE_W; i++) begin
			bin[i] = ^(code_in >> i);
		end
	end

	assign low_mask = ~((slcd_pkg::CODE_W'(1) << lowest_bit) - slcd_pkg::CODE_W'(1));
	assign code_out = (use_gray ? bin : code_in) & low_mask;

endmodule

`default_nettype wire
